>>> sv/assert_macros.svh
// Assertion macros used by the reassembler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is high.
`define FR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define FR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/frag_reasm_pkg.sv
// Types and constants shared by the fragment reassembler modules.
`timescale 1ns / 1ps
package frag_reasm_pkg;

   localparam logic [7:0]  FRAG_MARK     = 8'hFF;
   localparam logic [15:0] TIMEOUT_RESET = 16'd500;
   localparam int          HEADER_LEN    = 3;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_TICK = 2'd1,
      KIND_READ = 2'd2,
      KIND_IDLE = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_NONE     = 4'd0,
      ST_ACCEPT   = 4'd1,
      ST_COMPLETE = 4'd2,
      ST_SHORT    = 4'd3,
      ST_ORDER    = 4'd4,
      ST_COUNT    = 4'd5,
      ST_OVERFLOW = 4'd6,
      ST_TIMEOUT  = 4'd7,
      ST_NOTFRAG  = 4'd8,
      ST_READ     = 4'd9
   } status_type;

   typedef enum logic [1:0] {
      FAULT_NONE     = 2'd0,
      FAULT_NOTFRAG  = 2'd1,
      FAULT_OVERFLOW = 2'd2
   } fault_type;

   // Classified item as it travels from the front end to the back end.
   typedef struct packed {
      kind_type    kind;
      logic        is_mark;
      logic        first;
      logic        last;
      logic [7:0]  data_byte;
      logic [9:0]  read_address;
   } item_type;

endpackage

>>> sv/frag_reasm_front.sv
// Front end: accepts request transfers and classifies them into items.
`timescale 1ns / 1ps
module frag_reasm_front
   import frag_reasm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // data_byte[7:0], read_address[17:8], zero pad
   input  logic [2:0]  req_tuser,   // mode[1:0], first_byte[2]
   input  logic        req_tlast,
   output logic        item_valid,
   output item_type    item,
   input  logic        item_ready
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   assign req_tready = !valid_ff || item_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      item_in              = item_ff;
      item_in.data_byte    = req_tdata[7:0];
      item_in.read_address = req_tdata[17:8];
      item_in.first        = req_tuser[2];
      item_in.last         = req_tlast;
      item_in.is_mark      = (req_tdata[7:0] == FRAG_MARK);
      unique case (req_tuser[1:0])
         2'd0: item_in.kind = KIND_BYTE;
         2'd1: item_in.kind = KIND_TICK;
         2'd2: item_in.kind = KIND_READ;
         default: item_in.kind = KIND_IDLE;
      endcase
   end

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> sv/frag_reasm_queue.sv
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
module frag_reasm_queue
   import frag_reasm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> sv/frag_reasm_back.sv
// Back end: frame state, frame store and the result register.
`timescale 1ns / 1ps
module frag_reasm_back
   import frag_reasm_pkg::*;
#(
   parameter int BUFFER_BYTES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] timeout_ms,
   input  logic        item_valid,
   output logic        item_ready,
   input  item_type    item,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [3:0]  rsp_status,
   output logic [10:0] rsp_frame_length,
   output logic [7:0]  rsp_read_data,
   output logic [31:0] rsp_dropped,
   output logic [31:0] rsp_completed
);

   localparam int AW   = $clog2(BUFFER_BYTES);
   localparam int SW   = $clog2(BUFFER_BYTES + 1);
   localparam int PW   = $clog2(BUFFER_BYTES + 9);
   localparam int SUMW = PW + 1;
   localparam logic [PW-1:0]   POS_CAP = PW'(BUFFER_BYTES + 8);
   localparam logic [SUMW-1:0] BUF_LIM = SUMW'(BUFFER_BYTES);
   localparam logic [SUMW-1:0] HDR     = SUMW'(HEADER_LEN);

   logic [7:0] frame_store [BUFFER_BYTES];

   logic [SW-1:0] stored_ff, stored_in;
   logic [7:0]    expected_ff, expected_in;
   logic [7:0]    received_ff, received_in;
   logic [15:0]   ms_ff, ms_in;
   logic [31:0]   drop_ff, drop_in;
   logic [31:0]   comp_ff, comp_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    pidx_ff, pidx_in;
   logic [7:0]    ptot_ff, ptot_in;
   fault_type     fault_ff, fault_in;

   logic          out_valid_ff, out_valid_in;
   status_type    status_ff, status_in;
   logic [10:0]   flen_ff, flen_in;
   logic          rd_sel_ff, rd_sel_in;
   logic [7:0]    rd_data_ff;

   logic          pop;
   logic          wr_en;
   logic [AW-1:0] wr_idx;
   logic [AW-1:0] rd_idx;
   logic          rd_en;

   assign item_ready = !out_valid_ff || rsp_tready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      logic [PW-1:0]   p;
      fault_type       f0, f1;
      logic [7:0]      idx1, tot1;
      logic [SUMW-1:0] base, addr, count, size, total;
      logic [SUMW-1:0] np;
      logic            fits;
      logic [SW-1:0]   s0, s1;
      logic [7:0]      e0, r0, r1;
      logic [15:0]     ms_t;
      logic [SW+10:0]  fl_ext;
      logic [AW+9:0]   ra_ext;

      stored_in    = stored_ff;
      expected_in  = expected_ff;
      received_in  = received_ff;
      ms_in        = ms_ff;
      drop_in      = drop_ff;
      comp_in      = comp_ff;
      pos_in       = pos_ff;
      pidx_in      = pidx_ff;
      ptot_in      = ptot_ff;
      fault_in     = fault_ff;
      status_in    = ST_NONE;
      flen_in      = 11'd0;
      rd_sel_in    = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      p     = item.first ? '0 : pos_ff;
      f0    = item.first ? FAULT_NONE : fault_ff;
      f1    = f0;
      idx1  = pidx_ff;
      tot1  = ptot_ff;
      base  = (pidx_ff == 8'd0) ? '0 : SUMW'(stored_ff);
      addr  = base + SUMW'(p) - HDR;
      fits  = (pidx_ff == 8'd0) ? 1'b1
            : (pidx_ff == received_ff) && (ptot_ff == expected_ff);
      np    = (SUMW'(p) + SUMW'(1) < SUMW'(POS_CAP)) ? SUMW'(p) + SUMW'(1)
                                                     : SUMW'(POS_CAP);
      count = np;
      size  = count - HDR;
      s0    = stored_ff;
      e0    = expected_ff;
      r0    = received_ff;
      s1    = stored_ff;
      r1    = received_ff;
      total = '0;
      ms_t  = (ms_ff != 16'hFFFF) ? ms_ff + 16'd1 : ms_ff;
      fl_ext = '0;
      wr_idx = addr[AW-1:0];
      ra_ext = {{AW{1'b0}}, item.read_address};
      rd_idx = ra_ext[AW-1:0];

      if (pop) begin
         unique case (item.kind)
            KIND_BYTE: begin
               if (p == '0) begin
                  if (!item.is_mark) begin
                     f1 = FAULT_NOTFRAG;
                  end
               end else if (p == PW'(1)) begin
                  idx1 = item.data_byte;
               end else if (p == PW'(2)) begin
                  tot1 = item.data_byte;
               end else if (f0 == FAULT_NONE) begin
                  if (addr >= BUF_LIM) begin
                     f1 = FAULT_OVERFLOW;
                  end else if (fits) begin
                     wr_en = 1'b1;
                  end
               end
               pidx_in = idx1;
               ptot_in = tot1;
               if (item.last) begin
                  pos_in   = '0;
                  fault_in = FAULT_NONE;
                  if (f1 == FAULT_NOTFRAG) begin
                     status_in = ST_NOTFRAG;
                  end else if (count < HDR) begin
                     drop_in   = drop_ff + 32'd1;
                     status_in = ST_SHORT;
                  end else begin
                     // index zero restarts the frame before the checks
                     if (idx1 == 8'd0) begin
                        s0    = '0;
                        e0    = tot1;
                        r0    = 8'd0;
                        ms_in = 16'd0;
                     end
                     stored_in   = s0;
                     expected_in = e0;
                     received_in = r0;
                     total       = SUMW'(s0) + size;
                     s1          = SW'(total);
                     r1          = r0 + 8'd1;
                     if (idx1 != r0) begin
                        drop_in     = drop_ff + 32'd1;
                        stored_in   = '0;
                        received_in = 8'd0;
                        status_in   = ST_ORDER;
                     end else if (tot1 != e0) begin
                        drop_in     = drop_ff + 32'd1;
                        stored_in   = '0;
                        received_in = 8'd0;
                        status_in   = ST_COUNT;
                     end else if (total > BUF_LIM) begin
                        drop_in     = drop_ff + 32'd1;
                        stored_in   = '0;
                        received_in = 8'd0;
                        status_in   = ST_OVERFLOW;
                     end else begin
                        ms_in = 16'd0;
                        if (r1 == e0) begin
                           comp_in     = comp_ff + 32'd1;
                           fl_ext      = {11'd0, s1};
                           flen_in     = fl_ext[10:0];
                           stored_in   = '0;
                           received_in = 8'd0;
                           status_in   = ST_COMPLETE;
                        end else begin
                           stored_in   = s1;
                           received_in = r1;
                           status_in   = ST_ACCEPT;
                        end
                     end
                  end
               end else begin
                  pos_in   = PW'(np);
                  fault_in = f1;
               end
            end
            KIND_TICK: begin
               ms_in = ms_t;
               if (received_ff != 8'd0 && received_ff < expected_ff
                   && ms_t > timeout_ms) begin
                  drop_in     = drop_ff + 32'd1;
                  stored_in   = '0;
                  received_in = 8'd0;
                  status_in   = ST_TIMEOUT;
               end
            end
            KIND_READ: begin
               status_in = ST_READ;
               rd_sel_in = (ra_ext < (AW + 10)'(BUFFER_BYTES));
               rd_en     = rd_sel_in;
            end
            KIND_IDLE: begin
               status_in = ST_NONE;
            end
            default: begin
               status_in = ST_NONE;
            end
         endcase
      end
   end

   always_comb begin
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff    <= '0;
         expected_ff  <= 8'd0;
         received_ff  <= 8'd0;
         ms_ff        <= 16'd0;
         drop_ff      <= 32'd0;
         comp_ff      <= 32'd0;
         pos_ff       <= '0;
         pidx_ff      <= 8'd0;
         ptot_ff      <= 8'd0;
         fault_ff     <= FAULT_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         stored_ff    <= stored_in;
         expected_ff  <= expected_in;
         received_ff  <= received_in;
         ms_ff        <= ms_in;
         drop_ff      <= drop_in;
         comp_ff      <= comp_in;
         pos_ff       <= pos_in;
         pidx_ff      <= pidx_in;
         ptot_ff      <= ptot_in;
         fault_ff     <= fault_in;
         out_valid_ff <= out_valid_in;
      end
      if (pop) begin
         status_ff <= status_in;
         flen_ff   <= flen_in;
         rd_sel_ff <= rd_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_store[wr_idx] <= item.data_byte;
      end
      if (rd_en) begin
         rd_data_ff <= frame_store[rd_idx];
      end
   end

   assign rsp_tvalid       = out_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_frame_length = flen_ff;
   assign rsp_read_data    = rd_sel_ff ? rd_data_ff : 8'd0;
   assign rsp_dropped      = drop_ff;
   assign rsp_completed    = comp_ff;

endmodule

>>> sv/fragment_reassembler_core.sv
// Fragment reassembler: top level tying front end, queue and back end together.
`timescale 1ns / 1ps
// Rebuilds one frame from a byte stream of fragment packets (0xFF, index,
// total, payload) into a BUFFER_BYTES frame store and returns one result per
// request: a packet byte, a millisecond tick, a store read or an idle request.
// The block takes one request per cycle and gives one result per cycle when the
// result side keeps tready high; the back end settles each item in the cycle
// it pops it, with one store write and one registered store read, which sets
// that rate. A request passes the front end register, the two-entry queue and
// the back end result register before its result is offered on rsp. The frame
// store has no clearing pass: read only bytes that a frame has written. Write
// timeout_ms on the csr port only while no request is in flight.
`include "assert_macros.svh"
module fragment_reassembler_core
   import frag_reasm_pkg::*;
#(
   parameter int BUFFER_BYTES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // data_byte[7:0], read_address[17:8], zero pad
   input  logic [2:0]  req_tuser,   // mode[1:0], first_byte[2]
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // frame_length[10:0], read_data[18:11],
                                    // dropped_frames[50:19], completed_frames[82:51], pad
   output logic [3:0]  rsp_tuser,   // status[3:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // timeout_ms
);

   logic        front_valid, front_ready;
   item_type    front_item;
   logic        queue_valid, queue_ready;
   item_type    queue_item;
   logic [15:0] timeout_ff;
   logic [3:0]  status;
   logic [10:0] frame_length;
   logic [7:0]  read_data;
   logic [31:0] dropped, completed;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         timeout_ff <= csr_data;
      end
   end

   frag_reasm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .item_valid (front_valid),
      .item       (front_item),
      .item_ready (front_ready)
   );

   frag_reasm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_item   (queue_item)
   );

   frag_reasm_back #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .timeout_ms       (timeout_ff),
      .item_valid       (queue_valid),
      .item_ready       (queue_ready),
      .item             (queue_item),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_status       (status),
      .rsp_frame_length (frame_length),
      .rsp_read_data    (read_data),
      .rsp_dropped      (dropped),
      .rsp_completed    (completed)
   );

   assign rsp_tuser = status;
   assign rsp_tdata = {5'd0, completed, dropped, read_data, frame_length};

   // completion count moves only together with a completion result
   `FR_ASSERT(a_comp_with_status, clock, reset,
      (completed != $past(completed)) |-> (rsp_tvalid && status == ST_COMPLETE),
      "completion count changed without a complete result")
   // frame length is reported only with a completion
   `FR_ASSERT(a_len_only_complete, clock, reset,
      (rsp_tvalid && status != ST_COMPLETE) |-> (frame_length == 11'd0),
      "frame length set on a non-complete result")
   // store data is reported only for a read
   `FR_ASSERT(a_data_only_read, clock, reset,
      (rsp_tvalid && status != ST_READ) |-> (read_data == 8'd0),
      "read data set on a non-read result")
   // nothing leaves during or right after reset
   `FR_ASSERT_ALWAYS(a_quiet_after_reset, clock, reset |=> !rsp_tvalid,
      "result valid right after reset")

endmodule
